### rtl/homogeneous_point_transform_assert.svh
// Assertion macros for the homogeneous point transform.
// Used by the port-level checker; needs nothing else.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH

// Same-cycle implication under reset.
`define HPT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication under reset.
`define HPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/hpt_pkg.sv
// Shared types, codes and helpers for the homogeneous point transform.
// No dependencies.
package hpt_pkg;

   localparam int ACC_W     = 51;   // row result width, sign included
   localparam int NUM_W     = 67;   // dividend magnitude, |a| shifted by 16
   localparam int DSH_W     = 84;   // divisor magnitude shifted by 33
   localparam int DIV_STEPS = 34;   // quotient bits; values beyond the Q16.16 limits saturate
   localparam int Q_DEPTH   = 4;

   localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
   localparam logic signed [31:0] MAX_Q16 = 32'sh7fff_ffff;
   localparam logic signed [31:0] MIN_Q16 = 32'sh8000_0000;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_POINT = 2'd1;
   localparam logic [1:0] REQ_DIR   = 2'd2;

   typedef enum logic [1:0] {OP_WRITE, OP_POINT, OP_DIR} op_type;
   typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_DONE} div_state_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [3:0]         entry_index;
      logic signed [31:0] entry_value;
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [31:0] z_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] x_out;
      logic signed [31:0] y_out;
      logic signed [31:0] z_out;
      logic               w_zero;
      logic               saturated;
   } rsp_payload_type;

   typedef struct packed {
      op_type             op;
      logic [3:0]         entry_index;
      logic signed [31:0] entry_value;
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [31:0] z_in;
   } item_type;

   typedef struct packed {
      op_type                   op;
      logic [2:0][ACC_W-1:0]    a;
      logic [ACC_W-1:0]         w;
   } row_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Saturate a row value to Q16.16; bit 32 is the clip flag.
   function automatic logic [32:0] clip_q16(input logic signed [ACC_W-1:0] v);
      logic [32:0] r;
      if (v > ACC_W'(MAX_Q16)) begin
         r = {1'b1, MAX_Q16};
      end else if (v < ACC_W'(MIN_Q16)) begin
         r = {1'b1, MIN_Q16};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

### rtl/homogeneous_point_transform.sv
// Homogeneous 4x4 point transform, signed Q16.16. Direction items and points
// whose w is zero flow through at one item per cycle while the divider is
// idle and the output is not stalled; they pass through the queue and the
// product, row-sum and output registers. A point with nonzero w takes the
// perspective divider, which produces one quotient bit per cycle for all three
// coordinates at once, while later items wait in the queue and the pipeline.
// Matrix writes act in order with the transforms around them. Unused request
// codes are accepted and dropped. The matrix resets to identity.
module homogeneous_point_transform #(
   parameter int QUEUE_DEPTH = hpt_pkg::Q_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hpt_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hpt_pkg::rsp_payload_type rsp_data
);
   logic                     q_valid, q_ready;
   hpt_pkg::item_type        q_data;
   logic                     s2_valid, s2_take;
   hpt_pkg::row_type         s2_data;
   hpt_pkg::div_status_type  div_status;
   hpt_pkg::rsp_payload_type div_res, direct_res;
   logic                     out_free, div_idle, div_pop, div_start, s2_is_div;
   logic                     direct_load;
   logic                     rsp_vld_ff, rsp_vld_in;
   hpt_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic [32:0]              clip [3];

   hpt_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_ready, .q_data
   );

   hpt_mac u_mac (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .s2_valid, .s2_take, .s2_data
   );

   hpt_div u_div (
      .clock, .reset, .start(div_start), .a(s2_data.a), .w(s2_data.w),
      .res_take(div_pop), .status(div_status), .result(div_res)
   );

   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign div_idle  = !div_status.busy && !div_status.done;
   assign div_pop   = div_status.done && out_free;
   assign s2_is_div = (s2_data.op == hpt_pkg::OP_POINT) && (s2_data.w != '0);
   assign div_start = s2_valid && s2_is_div && div_idle;
   // Items that skip the divider must wait for it to drain to keep order.
   assign direct_load = s2_valid && !s2_is_div && div_idle && out_free;
   assign s2_take     = div_start || direct_load;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         clip[i] = hpt_pkg::clip_q16(s2_data.a[i]);
      end
      if (s2_data.op == hpt_pkg::OP_POINT) begin
         direct_res = '{x_out: '0, y_out: '0, z_out: '0, w_zero: 1'b1,
                        saturated: 1'b0};
      end else begin
         direct_res.x_out     = clip[0][31:0];
         direct_res.y_out     = clip[1][31:0];
         direct_res.z_out     = clip[2][31:0];
         direct_res.w_zero    = 1'b0;
         direct_res.saturated = clip[0][32] | clip[1][32] | clip[2][32];
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff && !rsp_ready;
      rsp_in     = rsp_ff;
      if (div_pop) begin
         rsp_vld_in = 1'b1;
         rsp_in     = div_res;
      end else if (direct_load) begin
         rsp_vld_in = 1'b1;
         rsp_in     = direct_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
endmodule

### rtl/hpt_front.sv
// Front end: takes request items, drops unused codes, queues the rest.
// Depends on hpt_pkg.
module hpt_front #(
   parameter int DEPTH = hpt_pkg::Q_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hpt_pkg::req_payload_type req_data,
   output logic                     q_valid,
   input  logic                     q_ready,
   output hpt_pkg::item_type        q_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   hpt_pkg::item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   hpt_pkg::item_type item;
   logic keep, push, pop;

   always_comb begin
      item.entry_index = req_data.entry_index;
      item.entry_value = req_data.entry_value;
      item.x_in        = req_data.x_in;
      item.y_in        = req_data.y_in;
      item.z_in        = req_data.z_in;
      item.op          = hpt_pkg::OP_WRITE;
      keep             = 1'b1;
      case (req_data.req_type)
         hpt_pkg::REQ_WRITE: item.op = hpt_pkg::OP_WRITE;
         hpt_pkg::REQ_POINT: item.op = hpt_pkg::OP_POINT;
         hpt_pkg::REQ_DIR:   item.op = hpt_pkg::OP_DIR;
         default:            keep    = 1'b0;
      endcase
   end

   assign req_ready = (cnt_ff != CW'(DEPTH));
   assign push      = req_valid && req_ready && keep;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_valid && q_ready;
   assign q_data    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= item;
      end
   end
endmodule

### rtl/hpt_mac.sv
// Back end arithmetic: holds the matrix, applies writes in order, forms the
// twelve products and the four row sums. Depends on hpt_pkg.
module hpt_mac (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  hpt_pkg::item_type q_data,
   output logic              s2_valid,
   input  logic              s2_take,
   output hpt_pkg::row_type  s2_data
);
   logic signed [31:0] mat_ff [16];
   logic               s1_vld_ff, s1_vld_in;
   hpt_pkg::op_type    s1_op_ff;
   logic signed [63:0] prod_ff [12];
   logic signed [63:0] prod_in [12];
   logic signed [31:0] tr_ff [4];
   logic               s2_vld_ff, s2_vld_in;
   hpt_pkg::row_type   s2_ff, s2_in;
   logic               s1_en, s2_en, s1_take, pop;
   logic signed [31:0] coord [3];
   logic signed [65:0] sum66 [4];
   logic signed [hpt_pkg::ACC_W-1:0] dot [4];

   assign s2_en   = !s2_vld_ff || s2_take;
   assign s1_take = s1_vld_ff && s2_en;
   assign s1_en   = !s1_vld_ff || s1_take;
   assign q_ready = s1_en;
   assign pop     = q_valid && s1_en;

   assign coord[0] = q_data.x_in;
   assign coord[1] = q_data.y_in;
   assign coord[2] = q_data.z_in;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r*3+c] = mat_ff[r*4+c] * coord[c];
         end
      end
   end

   assign s1_vld_in = s1_en ? (pop && q_data.op != hpt_pkg::OP_WRITE) : s1_vld_ff;

   // Exact sum, then floor to Q16.16 by taking the upper bits.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum66[r] = 66'(prod_ff[r*3]) + 66'(prod_ff[r*3+1]) + 66'(prod_ff[r*3+2]);
         dot[r]   = hpt_pkg::ACC_W'($signed(sum66[r][65:16]));
      end
      s2_in.op = s1_op_ff;
      for (int r = 0; r < 3; r++) begin
         if (s1_op_ff == hpt_pkg::OP_POINT) begin
            s2_in.a[r] = dot[r] + hpt_pkg::ACC_W'(tr_ff[r]);
         end else begin
            s2_in.a[r] = dot[r];
         end
      end
      s2_in.w = dot[3] + hpt_pkg::ACC_W'(tr_ff[3]);
   end

   assign s2_vld_in = s2_en ? s1_take : s2_vld_ff;
   assign s2_valid  = s2_vld_ff;
   assign s2_data   = s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= (i % 5 == 0) ? hpt_pkg::ONE_Q16 : '0;
         end
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         if (pop && q_data.op == hpt_pkg::OP_WRITE) begin
            mat_ff[q_data.entry_index] <= q_data.entry_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_op_ff <= q_data.op;
         prod_ff  <= prod_in;
         for (int r = 0; r < 4; r++) begin
            tr_ff[r] <= mat_ff[r*4+3];
         end
      end
      if (s2_en) begin
         s2_ff <= s2_in;
      end
   end
endmodule

### rtl/hpt_div.sv
// Perspective divide: three restoring dividers sharing one divisor, one
// quotient bit per cycle, with saturation. Depends on hpt_pkg.
module hpt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [2:0][hpt_pkg::ACC_W-1:0] a,
   input  logic [hpt_pkg::ACC_W-1:0]      w,
   input  logic                          res_take,
   output hpt_pkg::div_status_type       status,
   output hpt_pkg::rsp_payload_type      result
);
   localparam int NW = hpt_pkg::NUM_W;
   localparam int DW = hpt_pkg::DSH_W;
   localparam int QW = hpt_pkg::DIV_STEPS;
   localparam int CW = $clog2(hpt_pkg::DIV_STEPS);

   hpt_pkg::div_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] dsh_ff, dsh_in;
   logic [NW-1:0] rem_ff [3];
   logic [NW-1:0] rem_in [3];
   logic [QW-1:0] q_ff [3];
   logic [QW-1:0] q_in [3];
   logic          neg_ff [3];
   logic          neg_in [3];
   logic [hpt_pkg::ACC_W-1:0] mw, ma [3];
   logic          ge [3];
   logic [32:0]   lane_res [3];
   logic          run;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hpt_pkg::DIV_IDLE: if (start) state_in = hpt_pkg::DIV_RUN;
         hpt_pkg::DIV_RUN:  if (cnt_ff == '0) state_in = hpt_pkg::DIV_DONE;
         hpt_pkg::DIV_DONE: if (res_take) state_in = hpt_pkg::DIV_IDLE;
         default:           state_in = hpt_pkg::DIV_IDLE;
      endcase
   end

   always_comb begin
      status.busy = (state_ff == hpt_pkg::DIV_RUN);
      status.done = (state_ff == hpt_pkg::DIV_DONE);
      run         = (state_ff == hpt_pkg::DIV_RUN);
   end

   always_comb begin
      mw     = w[hpt_pkg::ACC_W-1] ? -w : w;
      dsh_in = dsh_ff;
      cnt_in = cnt_ff;
      if (start) begin
         dsh_in = {mw, 33'b0};
         cnt_in = CW'(QW - 1);
      end else if (run) begin
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         ma[i]     = a[i][hpt_pkg::ACC_W-1] ? -a[i] : a[i];
         ge[i]     = {(DW - NW)'(0), rem_ff[i]} >= dsh_ff;
         rem_in[i] = rem_ff[i];
         q_in[i]   = q_ff[i];
         neg_in[i] = neg_ff[i];
         if (start) begin
            rem_in[i] = {ma[i], 16'b0};
            q_in[i]   = '0;
            neg_in[i] = a[i][hpt_pkg::ACC_W-1] ^ w[hpt_pkg::ACC_W-1];
         end else if (run) begin
            rem_in[i] = ge[i] ? rem_ff[i] - dsh_ff[NW-1:0] : rem_ff[i];
            q_in[i]   = {q_ff[i][QW-2:0], ge[i]};
         end
      end
   end

   // A negative result may reach one more than the positive limit.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!neg_ff[i]) begin
            if (q_ff[i] > QW'(32'h7fff_ffff)) begin
               lane_res[i] = {1'b1, hpt_pkg::MAX_Q16};
            end else begin
               lane_res[i] = {1'b0, q_ff[i][31:0]};
            end
         end else begin
            if (q_ff[i] > QW'(32'h8000_0000)) begin
               lane_res[i] = {1'b1, hpt_pkg::MIN_Q16};
            end else begin
               lane_res[i] = {1'b0, 32'(-q_ff[i])};
            end
         end
      end
      result.x_out     = lane_res[0][31:0];
      result.y_out     = lane_res[1][31:0];
      result.z_out     = lane_res[2][31:0];
      result.w_zero    = 1'b0;
      result.saturated = lane_res[0][32] | lane_res[1][32] | lane_res[2][32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hpt_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dsh_ff <= dsh_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end
endmodule

### rtl/hpt_checker.sv
// Port-level checks for the homogeneous point transform, bound to the top.
// Depends on hpt_pkg and the assertion macro header.
`include "homogeneous_point_transform_assert.svh"

module hpt_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input hpt_pkg::rsp_payload_type rsp_data
);
   logic x_edge, y_edge, z_edge;
   logic rsp_stall, coords_zero;

   assign x_edge = (rsp_data.x_out == hpt_pkg::MAX_Q16) ||
                   (rsp_data.x_out == hpt_pkg::MIN_Q16);
   assign y_edge = (rsp_data.y_out == hpt_pkg::MAX_Q16) ||
                   (rsp_data.y_out == hpt_pkg::MIN_Q16);
   assign z_edge = (rsp_data.z_out == hpt_pkg::MAX_Q16) ||
                   (rsp_data.z_out == hpt_pkg::MIN_Q16);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign coords_zero = (rsp_data.x_out == '0) && (rsp_data.y_out == '0) &&
                        (rsp_data.z_out == '0);

   `HPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `HPT_ASSERT_NOW(a_wzero_clean, clock, reset, rsp_valid && rsp_data.w_zero, coords_zero && !rsp_data.saturated)
   `HPT_ASSERT_NOW(a_sat_at_limit, clock, reset, rsp_valid && rsp_data.saturated, x_edge || y_edge || z_edge)
endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_data
);
